// ===== design/mpel_pkg.sv =====
// ----------------------------------------------------------------------------
// mpel_pkg - shared types and constants for the MED predict/encrypt labeler
// Class codes, register indexes, reset values and the label code table.
// ----------------------------------------------------------------------------
package mpel_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int PIX_W    = 8;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 12;
	localparam int CFG_W    = 12;
	localparam int ERR_W    = 9;
	localparam int CLASS_W  = 2;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd5;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd4;

	localparam logic [PIX_W-1:0] PARAM_BYTE = 8'h32;

	typedef logic [CLASS_W-1:0] class_t;
	localparam class_t CLASS_REF   = 2'd0;
	localparam class_t CLASS_EMBED = 2'd1;
	localparam class_t CLASS_PLAIN = 2'd2;
	localparam class_t CLASS_PARAM = 2'd3;

	typedef logic reg_index_t;
	localparam reg_index_t REG_WIDTH  = 1'b0;
	localparam reg_index_t REG_HEIGHT = 1'b1;

	// Bit-reversed 3-bit code of (error + 5), indexed by error + 3.
	function automatic logic [2:0] label_code(input logic [2:0] idx);
		logic [2:0] code;
		case (idx)
			3'd0: code = 3'd2;
			3'd1: code = 3'd6;
			3'd2: code = 3'd1;
			3'd3: code = 3'd5;
			3'd4: code = 3'd3;
			3'd5: code = 3'd7;
			default: code = 3'd0;
		endcase
		return code;
	endfunction

endpackage

// ===== design/mpel_ram.sv =====
// ----------------------------------------------------------------------------
// mpel_ram - generic single-clock RAM
// One write port, one read port, registered read; a read of the address being
// written in the same cycle returns the old data. Read data holds without re.
// ----------------------------------------------------------------------------
module mpel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/med_predict_encrypt_label_unit.sv =====
// ----------------------------------------------------------------------------
// med_predict_encrypt_label_unit - MED predictor, key XOR and pixel labeler
// Raster pixels in; encrypted, labeled pixels out with class and error.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   in       | in_valid / in_stall  | pixel, key_byte
//   out      | out_valid / out_stall| marked_pixel, pixel_class, pred_error,
//            |                      | image_end
//   cfg      | cfg_wr_en            | cfg_index, cfg_data
//
// One beat per cycle while out_stall is low; stage 1 feeds the output register.
// The line store is read at accept and written with the new pixel in the same
// cycle, so the single write/read port pair sets the one-beat-per-cycle rate.
// Reset clears counters, neighbor registers and valids; no clearing pass.
// in_stall rises only when the prediction stage is full and the output beat
// is stalled.
// ----------------------------------------------------------------------------
module med_predict_encrypt_label_unit
	import mpel_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [PIX_W-1:0]           pixel,
	input  logic [PIX_W-1:0]           key_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [PIX_W-1:0]           marked_pixel,
	output logic [CLASS_W-1:0]         pixel_class,
	output logic signed [ERR_W-1:0]    pred_error,
	output logic                       image_end,
	input  logic                       cfg_wr_en,
	input  reg_index_t                 cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int CMPW = ((CW > WIDTH_W) ? CW : WIDTH_W) + 1;
	localparam int RW   = HEIGHT_W + 1;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CW-1:0]       col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [PIX_W-1:0]    left_q;
	logic [PIX_W-1:0]    ul_q;

	logic                valid_s1;
	logic [PIX_W-1:0]    pix_s1;
	logic [PIX_W-1:0]    key_s1;
	logic [PIX_W-1:0]    left_s1;
	logic                ref_s1;
	logic                end_s1;

	logic                out_valid_q;
	logic [PIX_W-1:0]    marked_q;
	class_t              class_q;
	logic [ERR_W-1:0]    err_q;
	logic                end_q;

	logic                accept;
	logic                adv_s1;
	logic                last_col;
	logic                last_row;
	logic [CMPW-1:0]     col_next;
	logic [RW-1:0]       row_next;
	logic [PIX_W-1:0]    up;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	// raster position
	assign col_next = CMPW'(col_q) + CMPW'(1);
	assign row_next = RW'(row_q) + RW'(1);
	assign last_col = (col_next >= CMPW'(width_q)) || (col_q == CW'(MAX_WIDTH - 1));
	assign last_row = row_next >= RW'(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			left_q <= pixel;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_next[HEIGHT_W-1:0];
			end else begin
				col_q <= col_next[CW-1:0];
			end
		end
	end

	// line store: read upper neighbor and write current pixel at accept
	mpel_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (pixel),
		.re    (accept),
		.raddr (col_q),
		.rdata (up)
	);

	// stage 1 holds the beat while the line store answers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel;
			key_s1  <= key_byte;
			left_s1 <= left_q;
			ref_s1  <= (row_q == '0) || (col_q == '0);
			end_s1  <= last_col && last_row;
		end
	end

	// upper-left is the upper neighbor of the previous beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ul_q <= '0;
		end else if (adv_s1) begin
			ul_q <= up;
		end
	end

	// MED prediction and labeling
	logic [PIX_W-1:0]   lo;
	logic [PIX_W-1:0]   hi;
	logic [PIX_W+1:0]   grad;
	logic [PIX_W-1:0]   pred;
	logic [ERR_W-1:0]   err;
	logic [PIX_W-1:0]   enc;
	logic               embed;
	logic [PIX_W-1:0]   marked_d;
	class_t             class_d;
	logic [ERR_W-1:0]   err_d;

	always_comb begin
		lo   = (left_s1 < up) ? left_s1 : up;
		hi   = (left_s1 < up) ? up : left_s1;
		grad = {2'b00, left_s1} + {2'b00, up} - {2'b00, ul_q};
		if (ul_q <= lo) begin
			pred = hi;
		end else if (ul_q >= hi) begin
			pred = lo;
		end else begin
			pred = grad[PIX_W-1:0];
		end
		err   = {1'b0, pix_s1} - {1'b0, pred};
		enc   = pix_s1 ^ key_s1;
		embed = ($signed(err) >= -9'sd3) && ($signed(err) <= 9'sd2);

		if (ref_s1) begin
			marked_d = enc;
			class_d  = CLASS_REF;
			err_d    = '0;
		end else if (end_s1) begin
			marked_d = PARAM_BYTE;
			class_d  = CLASS_PARAM;
			err_d    = err;
		end else if (embed) begin
			marked_d = {enc[PIX_W-1:3], label_code(err[2:0] + 3'd3)};
			class_d  = CLASS_EMBED;
			err_d    = err;
		end else begin
			marked_d = {enc[PIX_W-1:2], 2'b00};
			class_d  = CLASS_PLAIN;
			err_d    = err;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			marked_q <= marked_d;
			class_q  <= class_d;
			err_q    <= err_d;
			end_q    <= end_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign marked_pixel = marked_q;
	assign pixel_class  = class_q;
	assign pred_error   = $signed(err_q);
	assign image_end    = end_q;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - regression for med_predict_encrypt_label_unit
// Drives raster pixels with key bytes through the valid/stall input channel,
// predicts every output beat with a local MED/XOR/label model, and compares
// each output beat field by field. Image geometry is rewritten between
// phases while the pipe is empty; the input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module testbench;
	import mpel_pkg::*;

	localparam int MAX_W          = MAX_WIDTH_DEF;
	localparam int DIRECTED_ITEMS = 24;
	localparam int RANDOM_ITEMS   = 1800;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 8;
	localparam int IDLE_LIMIT     = 400;

	// 5x4 image at reset geometry; interior errors cover -3..2, +3, -4 and both extremes
	localparam logic [PIX_W-1:0] FLAT_IMAGE [20] = '{
		8'd0,   8'd100, 8'd100, 8'd100, 8'd100,
		8'd100, 8'd97,  8'd95,  8'd94,  8'd94,
		8'd100, 8'd98,  8'd98,  8'd255, 8'd0,
		8'd100, 8'd101, 8'd97,  8'd255, 8'd255
	};

	typedef enum logic [1:0] {OP_PIXEL, OP_CONFIG, OP_DRAIN} plan_op_e;
	typedef enum logic [1:0] {CONTENT_SMOOTH, CONTENT_SPIKY, CONTENT_NOISE} content_e;

	typedef struct packed {
		plan_op_e         op;
		logic [PIX_W-1:0] pix;
		logic [PIX_W-1:0] key_val;
		reg_index_t       idx;
		logic [CFG_W-1:0] data;
	} plan_step_t;

	typedef struct packed {
		logic [PIX_W-1:0]        marked;
		class_t                  label_class;
		logic signed [ERR_W-1:0] err;
		logic                    image_end;
	} pix_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [PIX_W-1:0]        pixel = '0;
	logic [PIX_W-1:0]        key_byte = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [PIX_W-1:0]        marked_pixel;
	logic [CLASS_W-1:0]      pixel_class;
	logic signed [ERR_W-1:0] pred_error;
	logic                    image_end;
	logic                    cfg_wr_en = 1'b0;
	reg_index_t              cfg_index = REG_WIDTH;
	logic [CFG_W-1:0]        cfg_data = '0;

	plan_step_t  plan_q[$];
	pix_result_t expected_q[$];

	// predictor state
	logic [PIX_W-1:0]    row_buf [MAX_W];
	logic [PIX_W-1:0]    left_pix, upleft_pix;
	int unsigned         col_pos;
	logic [HEIGHT_W-1:0] row_pos;
	logic [WIDTH_W-1:0]  width_cfg;
	logic [HEIGHT_W-1:0] height_cfg;

	int items_planned = 0;
	int mismatches = 0;
	int beats_checked = 0;
	int reg_writes = 0;
	int ends_seen = 0;
	int class_seen [4] = '{0, 0, 0, 0};
	int gap_left = 0;
	int quiet_cycles = 0;
	int send_mode = 0;
	int hold_left = 0;
	int recv_mode = 0;
	logic send_next, wr_next;
	plan_step_t head;
	pix_result_t want;

	med_predict_encrypt_label_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel        (pixel),
		.key_byte     (key_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.marked_pixel (marked_pixel),
		.pixel_class  (pixel_class),
		.pred_error   (pred_error),
		.image_end    (image_end),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int draw_wait(input int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 3);
			default: return $urandom_range(0, 18);
		endcase
	endfunction

	// MED prediction, key XOR and labeling for one pixel; advances raster state
	function automatic pix_result_t predict_beat(input logic [PIX_W-1:0] pix,
			input logic [PIX_W-1:0] key_val);
		pix_result_t r;
		int unsigned col;
		logic [PIX_W-1:0] up, enc;
		logic last_col, last_row;
		int lo_n, hi_n, guess, err;
		logic [2:0] code_in;
		col = (col_pos < MAX_W) ? col_pos : 0;
		up = row_buf[col];
		enc = pix ^ key_val;
		last_col = (col + 1 >= width_cfg) || (col == MAX_W - 1);
		last_row = (row_pos + 1 >= height_cfg);
		r.image_end = last_col && last_row;
		err = 0;
		if (row_pos == 0 || col == 0) begin
			r.marked = enc;
			r.label_class = CLASS_REF;
		end else begin
			lo_n = (left_pix < up) ? int'(left_pix) : int'(up);
			hi_n = (left_pix < up) ? int'(up) : int'(left_pix);
			if (upleft_pix <= lo_n)
				guess = hi_n;
			else if (upleft_pix >= hi_n)
				guess = lo_n;
			else
				guess = int'(left_pix) + int'(up) - int'(upleft_pix);
			err = int'(pix) - guess;
			if (r.image_end) begin
				r.marked = PARAM_BYTE;
				r.label_class = CLASS_PARAM;
			end else if (err >= -3 && err <= 2) begin
				// label is error+5 with its three bits reversed
				code_in = 3'(err + 5);
				r.marked = {enc[7:3], code_in[0], code_in[1], code_in[2]};
				r.label_class = CLASS_EMBED;
			end else begin
				r.marked = {enc[7:2], 2'b00};
				r.label_class = CLASS_PLAIN;
			end
		end
		r.err = err[ERR_W-1:0];
		upleft_pix = up;
		left_pix = pix;
		row_buf[col] = pix;
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = col + 1;
		end
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] make_pixel(input content_e style, input int base);
		int v;
		case (style)
			CONTENT_NOISE: v = $urandom_range(0, 255);
			CONTENT_SPIKY: begin
				if ($urandom_range(0, 7) == 0)
					v = $urandom_range(0, 1) ? 255 : 0;
				else
					v = base + int'($urandom_range(0, 6)) - 3;
			end
			default: v = base + int'($urandom_range(0, 6)) - 3;
		endcase
		return v[PIX_W-1:0];
	endfunction

	task automatic add_pixel(input logic [PIX_W-1:0] pix, input logic [PIX_W-1:0] key_val);
		plan_q.push_back('{OP_PIXEL, pix, key_val, REG_WIDTH, '0});
		items_planned++;
	endtask

	task automatic add_config(input reg_index_t idx, input logic [CFG_W-1:0] value);
		plan_q.push_back('{OP_CONFIG, '0, '0, idx, value});
	endtask

	task automatic add_pixels(input int count, input content_e style);
		int base;
		base = $urandom_range(8, 247);
		for (int i = 0; i < count; i++)
			add_pixel(make_pixel(style, base), 8'($urandom));
	endtask

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// driver: issues planned pixels and register writes, predicts each sent beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel <= '0;
			key_byte <= '0;
			cfg_wr_en <= 1'b0;
			cfg_index <= REG_WIDTH;
			cfg_data <= '0;
			gap_left = 0;
			quiet_cycles = 0;
			for (int i = 0; i < MAX_W; i++)
				row_buf[i] = '0;
			left_pix = '0;
			upleft_pix = '0;
			col_pos = 0;
			row_pos = '0;
			width_cfg = WIDTH_RST;
			height_cfg = HEIGHT_RST;
		end else begin
			send_next = in_valid && in_stall;
			wr_next = 1'b0;
			if (in_valid && !in_stall)
				expected_q.push_back(predict_beat(pixel, key_byte));
			quiet_cycles = (expected_q.size() == 0 && !in_valid) ? quiet_cycles + 1 : 0;
			if (!send_next && plan_q.size() != 0) begin
				head = plan_q[0];
				case (head.op)
					OP_PIXEL: begin
						if (gap_left != 0) begin
							gap_left--;
						end else begin
							send_next = 1'b1;
							pixel <= head.pix;
							key_byte <= head.key_val;
							void'(plan_q.pop_front());
							if ($urandom_range(0, 63) == 0)
								send_mode = $urandom_range(0, 2);
							gap_left = draw_wait(send_mode);
						end
					end
					default: begin
						// hold until the pipe has drained and settled
						if (quiet_cycles >= SETTLE_CYCLES) begin
							if (head.op == OP_CONFIG) begin
								wr_next = 1'b1;
								cfg_index <= head.idx;
								cfg_data <= head.data;
								reg_writes++;
								if (head.idx == REG_WIDTH)
									width_cfg = head.data[WIDTH_W-1:0];
								else
									height_cfg = head.data[HEIGHT_W-1:0];
							end
							void'(plan_q.pop_front());
						end
					end
				endcase
			end
			in_valid <= send_next;
			cfg_wr_en <= wr_next;
		end
	end

	// monitor: checks each output beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				beats_checked++;
				if (expected_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected beat: marked %02h class %0d err %0d end %0b",
						marked_pixel, pixel_class, pred_error, image_end));
				end else begin
					want = expected_q.pop_front();
					if (marked_pixel !== want.marked || pixel_class !== want.label_class ||
							pred_error !== want.err || image_end !== want.image_end)
						flag_mismatch($sformatf(
							"beat %0d: got marked %02h class %0d err %0d end %0b, want %02h %0d %0d %0b",
							beats_checked, marked_pixel, pixel_class, pred_error, image_end,
							want.marked, want.label_class, want.err, want.image_end));
					else begin
						class_seen[pixel_class]++;
						if (image_end)
							ends_seen++;
					end
				end
				if ($urandom_range(0, 63) == 0)
					recv_mode = $urandom_range(0, 2);
				hold_left = draw_wait(recv_mode);
			end else if (hold_left != 0) begin
				hold_left--;
			end
			out_stall <= (hold_left != 0);
		end
	end

	initial begin
		int new_w, new_h, span, pick, idle_cycles, tail_cycles;
		content_e style;

		// directed: reset geometry image, then one-pixel rows and images
		for (int i = 0; i < 20; i++)
			add_pixel(FLAT_IMAGE[i], (i % 2) ? 8'h00 : 8'hFF);
		add_config(REG_WIDTH, 12'd1);
		add_config(REG_HEIGHT, 12'd1);
		add_pixel(8'hFF, 8'h00);
		add_pixel(8'h00, 8'hFF);
		add_config(REG_WIDTH, 12'd0);
		add_config(REG_HEIGHT, 12'd0);
		add_pixel(8'h5A, 8'hA5);
		add_pixel(8'hA5, 8'h5A);

		// oversize width wraps at the line-store depth; fills every line-store entry
		add_config(REG_WIDTH, 12'hFFF);
		add_config(REG_HEIGHT, 12'd4095);
		add_pixels(MAX_W + 30, CONTENT_SMOOTH);
		add_config(REG_WIDTH, 12'd1024);
		add_pixels(10, CONTENT_SPIKY);
		add_config(REG_WIDTH, 12'd48);
		add_config(REG_HEIGHT, 12'd2);
		add_pixels(8, CONTENT_SMOOTH);

		while (items_planned < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			new_w = (pick < 5) ? 2 : (pick < 7) ? $urandom_range(0, 1) :
				(pick < 9) ? $urandom_range(13, 40) : $urandom_range(3, 12);
			pick = $urandom_range(0, 19);
			new_h = (pick < 5) ? 2 : (pick < 7) ? $urandom_range(0, 1) :
				(pick == 7) ? 4095 : $urandom_range(3, 6);
			pick = $urandom_range(0, 9);
			if (pick != 0)
				add_config(REG_WIDTH, CFG_W'(new_w));
			if (pick != 1)
				add_config(REG_HEIGHT, CFG_W'(new_h));
			span = ((new_w < 2) ? 1 : new_w) * ((new_h < 2) ? 1 : new_h);
			if (span > 160 || $urandom_range(0, 2) == 0)
				span = $urandom_range(1, 40);
			pick = $urandom_range(0, 9);
			style = (pick < 6) ? CONTENT_SMOOTH : (pick < 8) ? CONTENT_SPIKY : CONTENT_NOISE;
			add_pixels(span, style);
			if ($urandom_range(0, 5) == 0)
				plan_q.push_back('{OP_DRAIN, '0, '0, REG_WIDTH, '0});
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idle_cycles = 0;
		tail_cycles = 0;
		while (tail_cycles < TAIL_CYCLES && idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (plan_q.size() != 0 || in_valid || expected_q.size() != 0)
				tail_cycles = 0;
			else
				tail_cycles++;
		end

		if (idle_cycles >= IDLE_LIMIT) begin
			$display("no beat moved for %0d cycles, %0d predictions pending",
				idle_cycles, expected_q.size());
			$display("med_predict_encrypt_label_unit regression: fail");
		end else begin
			$display("%0d pixels checked under %0d register writes, %0d image ends, %0d mismatches",
				beats_checked, reg_writes, ends_seen, mismatches);
			$display("classes: %0d reference, %0d embeddable, %0d non-embeddable, %0d parameter",
				class_seen[0], class_seen[1], class_seen[2], class_seen[3]);
			if (mismatches == 0)
				$display("med_predict_encrypt_label_unit regression: pass");
			else
				$display("med_predict_encrypt_label_unit regression: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/mpel_pkg.sv
design/mpel_ram.sv
design/med_predict_encrypt_label_unit.sv
bench/testbench.sv
